@@ hw/rtl/ssfr_pkg.sv @@
package ssfr_pkg;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_HEADER = 3'd1;
    localparam logic [2:0] MODE_CMD    = 3'd2;
    localparam logic [2:0] MODE_DATA   = 3'd3;
    localparam logic [2:0] MODE_TAIL   = 3'd4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_TAIL   = 2'd3;

    localparam int HEADER_LEN = 5;
    localparam int CMD_LEN    = 2;
    localparam int TAIL_LEN   = 2;

    // byte positions inside the fixed segments
    localparam int POS_HDR_SOF    = 0;
    localparam int POS_HDR_LEN_LO = 1;
    localparam int POS_HDR_LEN_HI = 2;
    localparam int POS_HDR_SEQ    = 3;
    localparam int POS_CMD_LO     = 0;
    localparam int POS_TAIL_HI    = 0;

    localparam int TDATA_W = 88;

    typedef struct packed {
        logic       byte_en;     // store the accepted byte
        logic [2:0] mode;        // segment the byte belongs to
        logic       emit;        // byte completes header, command or tail
        logic       rd_en;       // read data buffer at rd_idx
        logic       drain_load;  // load buffered data byte into output
        logic       drain_last;  // final data beat of the segment
    } dp_cmd_t;

    function automatic int cnt_width(input int n);
        return (n > 7) ? $clog2(n + 1) : 3;
    endfunction

    function automatic int addr_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

@@ hw/rtl/ssfr_ctrl.sv @@
module ssfr_ctrl #(
    parameter int DATA_LEN = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              rx_byte,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [7:0]                              cfg_data,
    input  logic                                    slot_free,
    output ssfr_pkg::dp_cmd_t                       cmd,
    output logic [ssfr_pkg::cnt_width(DATA_LEN)-1:0]  wr_pos,
    output logic [ssfr_pkg::addr_width(DATA_LEN)-1:0] rd_idx
);
    import ssfr_pkg::*;

    localparam int CW = cnt_width(DATA_LEN);
    localparam int AW = addr_width(DATA_LEN);

    localparam logic [1:0] PH_RUN  = 2'd0;
    localparam logic [1:0] PH_READ = 2'd1;
    localparam logic [1:0] PH_LOAD = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    start_reg;

    logic          in_fire;
    logic          done;
    logic [2:0]    mode_nx;
    logic [CW-1:0] cnt_base;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] len_cur;
    logic [CW-1:0] len_nx;
    logic          store;
    logic          complete;
    logic          idx_last;

    function automatic logic [CW-1:0] seg_len(input logic [2:0] m);
        logic [CW-1:0] l;
        unique case (m)
            MODE_HEADER: l = CW'(HEADER_LEN);
            MODE_CMD:    l = CW'(CMD_LEN);
            MODE_DATA:   l = CW'(DATA_LEN);
            MODE_TAIL:   l = CW'(TAIL_LEN);
            default:     l = '0;
        endcase
        return l;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (phase_reg == PH_RUN) && slot_free;
    assign in_fire   = s_tvalid && s_tready;

    assign len_cur = seg_len(mode_reg);
    assign done    = (cnt_reg == len_cur);

    always_comb
    begin
        mode_nx = mode_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (rx_byte == start_reg)
                    mode_nx = MODE_HEADER;
            end
            MODE_HEADER:
            begin
                if (done)
                    mode_nx = MODE_CMD;
            end
            MODE_CMD:
            begin
                if (done)
                    mode_nx = MODE_DATA;
            end
            MODE_DATA:
            begin
                if (done)
                    mode_nx = MODE_TAIL;
            end
            MODE_TAIL:
            begin
                if (done && rx_byte == start_reg)
                    mode_nx = MODE_HEADER;
            end
            default: mode_nx = MODE_IDLE;
        endcase
    end

    assign len_nx   = seg_len(mode_nx);
    assign cnt_base = (mode_nx != mode_reg) ? '0 : cnt_reg;
    assign cnt_inc  = cnt_base + CW'(1);
    assign store    = (mode_nx != MODE_IDLE) && (cnt_base < len_nx);
    assign complete = store && (cnt_inc == len_nx);
    assign idx_last = (idx_reg == AW'(DATA_LEN - 1));

    assign wr_pos = cnt_base;
    assign rd_idx = idx_reg;

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;

        cmd            = '0;
        cmd.mode       = mode_nx;
        cmd.drain_last = idx_last;

        unique case (phase_reg)
            PH_RUN:
            begin
                if (in_fire)
                begin
                    mode_next   = mode_nx;
                    cnt_next    = store ? cnt_inc : cnt_base;
                    cmd.byte_en = store;
                    if (complete && mode_nx == MODE_DATA)
                    begin
                        phase_next = PH_READ;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.emit = complete;
                    end
                end
            end
            PH_READ:
            begin
                cmd.rd_en  = 1'b1;
                phase_next = PH_LOAD;
            end
            PH_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.drain_load = 1'b1;
                    if (idx_last)
                    begin
                        phase_next = PH_RUN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        phase_next = PH_READ;
                    end
                end
            end
            default: phase_next = PH_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RUN;
            mode_reg  <= MODE_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            start_reg <= 8'd165;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                start_reg <= cfg_data;
        end
    end

endmodule

@@ hw/rtl/ssfr_datapath.sv @@
module ssfr_datapath #(
    parameter int DATA_LEN = 12
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ssfr_pkg::dp_cmd_t                         cmd,
    input  logic [ssfr_pkg::cnt_width(DATA_LEN)-1:0]  wr_pos,
    input  logic [ssfr_pkg::addr_width(DATA_LEN)-1:0] rd_idx,
    input  logic [7:0]                                rx_byte,
    output logic                                      slot_free,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [ssfr_pkg::TDATA_W-1:0]              m_tdata,
    output logic [1:0]                                m_tuser,
    output logic                                      m_tlast
);
    import ssfr_pkg::*;

    localparam int CW = cnt_width(DATA_LEN);
    localparam int AW = addr_width(DATA_LEN);

    logic [7:0] data_mem [DATA_LEN];
    logic [7:0] rdata_reg;

    logic [7:0] sof_reg;
    logic [7:0] len_lo_reg;
    logic [7:0] len_hi_reg;
    logic [7:0] seq_reg;
    logic [7:0] cmd_lo_reg;
    logic [7:0] tail_hi_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  o_sof_reg;
    logic [15:0] o_len_reg;
    logic [7:0]  o_seq_reg;
    logic [7:0]  o_hcrc_reg;
    logic [15:0] o_cmd_reg;
    logic [15:0] o_fcrc_reg;
    logic [3:0]  o_idx_reg;
    logic [7:0]  o_val_reg;
    logic        o_last_reg;

    logic [AW+3:0] idx_wide;
    logic          load;

    assign idx_wide  = {{4{1'b0}}, rd_idx};
    assign slot_free = !out_valid_reg || m_tready;
    assign load      = cmd.emit || cmd.drain_load;

    // data buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.byte_en && cmd.mode == MODE_DATA)
            data_mem[wr_pos[AW-1:0]] <= rx_byte;
        if (cmd.rd_en)
            rdata_reg <= data_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_en)
        begin
            if (cmd.mode == MODE_HEADER)
            begin
                if (wr_pos == CW'(POS_HDR_SOF))
                    sof_reg <= rx_byte;
                if (wr_pos == CW'(POS_HDR_LEN_LO))
                    len_lo_reg <= rx_byte;
                if (wr_pos == CW'(POS_HDR_LEN_HI))
                    len_hi_reg <= rx_byte;
                if (wr_pos == CW'(POS_HDR_SEQ))
                    seq_reg <= rx_byte;
            end
            if (cmd.mode == MODE_CMD && wr_pos == CW'(POS_CMD_LO))
                cmd_lo_reg <= rx_byte;
            if (cmd.mode == MODE_TAIL && wr_pos == CW'(POS_TAIL_HI))
                tail_hi_reg <= rx_byte;
        end
    end

    // the completing byte is taken straight from the input
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_sof_reg  <= '0;
            o_len_reg  <= '0;
            o_seq_reg  <= '0;
            o_hcrc_reg <= '0;
            o_cmd_reg  <= '0;
            o_fcrc_reg <= '0;
            o_idx_reg  <= '0;
            o_val_reg  <= '0;
            o_last_reg <= 1'b1;
            if (cmd.drain_load)
            begin
                kind_reg   <= KIND_DATA;
                o_idx_reg  <= idx_wide[3:0];
                o_val_reg  <= rdata_reg;
                o_last_reg <= cmd.drain_last;
            end
            else
            begin
                unique case (cmd.mode)
                    MODE_HEADER:
                    begin
                        kind_reg   <= KIND_HEADER;
                        o_sof_reg  <= sof_reg;
                        o_len_reg  <= {len_hi_reg, len_lo_reg};
                        o_seq_reg  <= seq_reg;
                        o_hcrc_reg <= rx_byte;
                    end
                    MODE_CMD:
                    begin
                        kind_reg  <= KIND_CMD;
                        o_cmd_reg <= {rx_byte, cmd_lo_reg};
                    end
                    default:
                    begin
                        kind_reg   <= KIND_TAIL;
                        o_fcrc_reg <= {tail_hi_reg, rx_byte};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'b0000, o_val_reg, o_idx_reg, o_fcrc_reg, o_cmd_reg,
                       o_hcrc_reg, o_seq_reg, o_len_reg, o_sof_reg};

endmodule

@@ hw/rtl/segmented_serial_frame_receiver.sv @@
// Serial frame receiver: takes one received byte per s_tvalid/s_tready beat and walks
// a frame of a 5-byte header (start byte, length LE, sequence, CRC8), a 2-byte LE command
// id, a DATA_LEN-byte data segment and a 2-byte tail CRC16 sent high byte first. Each
// completed header, command or tail gives one m_* beat with tlast set; a completed data
// segment gives DATA_LEN beats, tlast on the final one. Fields not belonging to the
// segment kind read as zero. After the tail, bytes other than the start byte are dropped.
// A byte is taken only while the output register is free. The byte completing the data
// segment starts a readout: each beat is read from the data buffer's registered port,
// then loaded into the output register once free; no byte is taken until the last one
// is loaded. No CRC is checked. start_byte (reset 0xA5) is written through
// cfg_valid/cfg_data; the user must do so only while the block is idle (not enforced).
module segmented_serial_frame_receiver #(
    parameter int DATA_LEN = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] sof_byte, [23:8] payload_length, [31:24] seq_number, [39:32] header_crc,
    // [55:40] command_id, [71:56] frame_crc, [75:72] data_index, [83:76] data_value
    output logic [ssfr_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] seg_kind
    output logic                         m_tlast,   // last
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_data   // start_byte
);
    import ssfr_pkg::*;

    localparam int CW = cnt_width(DATA_LEN);
    localparam int AW = addr_width(DATA_LEN);

    dp_cmd_t       cmd;
    logic [CW-1:0] wr_pos;
    logic [AW-1:0] rd_idx;
    logic          slot_free;

    ssfr_ctrl #(
        .DATA_LEN (DATA_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .rx_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .slot_free (slot_free),
        .cmd       (cmd),
        .wr_pos    (wr_pos),
        .rd_idx    (rd_idx)
    );

    ssfr_datapath #(
        .DATA_LEN (DATA_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_pos    (wr_pos),
        .rd_idx    (rd_idx),
        .rx_byte   (s_tdata),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
